// ===== design/tick_driven_time_of_day_clock_unit_defines.svh =====
// Assertion macros for the time-of-day clock unit.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef TICK_DRIVEN_TIME_OF_DAY_CLOCK_UNIT_DEFINES_SVH
`define TICK_DRIVEN_TIME_OF_DAY_CLOCK_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TDC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define TDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tdc_pkg.sv =====
// Package for the time-of-day clock unit: request and result types,
// constants and the small constant-divisor helpers. Depends on nothing.
package tdc_pkg;

    localparam int unsigned RATE_W = 10;

    localparam logic [RATE_W-1:0] RATE_RESET      = 10'd200;
    localparam logic [3:0]        PRESCALE_RESET  = 4'd2;
    localparam logic [6:0]        HUNDREDTHS_LIMIT = 7'd100;
    localparam logic [8:0]        MINSEC_LIMIT    = 9'd60;
    localparam logic [8:0]        HOUR_LIMIT      = 9'd24;
    localparam logic [31:0]       CENTI_STEP      = 32'd100;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] load_second_bcd;
        logic [7:0] load_minute_bcd;
        logic [7:0] load_hour_bcd;
    } item_t;

    typedef struct packed {
        logic [6:0]  hundredths;
        logic [7:0]  seconds;
        logic [7:0]  minutes;
        logic [7:0]  hours;
        logic [31:0] boot_seconds;
        logic [31:0] precise_time;
        logic [31:0] tick_count;
        logic        resync_request;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [RATE_W-1:0] data;
    } cfg_wr_t;

    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] tens;
        tens = {4'd0, b[7:4]} * 8'd10;
        return tens + {4'd0, b[3:0]};
    endfunction

    // x / 100 by reciprocal, exact for all 10-bit x
    function automatic logic [3:0] div100(input logic [RATE_W-1:0] x);
        logic [23:0] p;
        p = {14'd0, x} * 24'd5243;
        return p[22:19];
    endfunction

    // m % 10 by reciprocal, exact for all 8-bit m
    function automatic logic [3:0] mod10(input logic [7:0] m);
        logic [15:0] p;
        logic [7:0]  q10;
        logic [7:0]  r;
        p   = {8'd0, m} * 16'd205;
        q10 = {3'd0, p[15:11]} * 8'd10;
        r   = m - q10;
        return r[3:0];
    endfunction

endpackage

// ===== design/tdc_ifs.sv =====
// Channel interfaces of the time-of-day clock unit: tick/load requests,
// results and the tick rate write port. Depends on tdc_pkg.
interface tdc_item_if;
    logic          valid;
    logic          ready;
    tdc_pkg::item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface tdc_result_if;
    logic             valid;
    logic             ready;
    tdc_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tdc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tdc_pkg::RATE_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/tdc_in_stage.sv =====
// Input register of the time-of-day clock unit: holds one request until
// the core takes it. Depends on tdc_pkg and tdc_ifs.
module tdc_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    tdc_item_if.sink          req,
    input  logic              take,
    output logic              held_valid,
    output tdc_pkg::item_t    held_item
);
    import tdc_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign req.ready  = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg <= req.item;
        end
    end

endmodule

// ===== design/tdc_core.sv =====
// Clock state and next-state logic of the time-of-day clock unit: tick
// counters, prescaler, time cascade and BCD load. Depends on tdc_pkg and the assertion macro header.
module tdc_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  tdc_pkg::cfg_wr_t  cfg_wr,
    input  logic              step,
    input  tdc_pkg::item_t    item,
    output tdc_pkg::result_t  result
);
    import tdc_pkg::*;
    `include "tick_driven_time_of_day_clock_unit_defines.svh"

    logic [RATE_W-1:0] rate_reg;
    logic [3:0]        limit_reg;
    logic [3:0]        prescale_reg,  prescale_next;
    logic [6:0]        hund_reg,      hund_next;
    logic [7:0]        sec_reg,       sec_next;
    logic [7:0]        min_reg,       min_next;
    logic [7:0]        hour_reg,      hour_next;
    logic [RATE_W-1:0] sub_reg,       sub_next;
    logic [31:0]       uptime_reg,    uptime_next;
    logic [31:0]       base_reg,      base_next;
    logic [31:0]       total_reg,     total_next;
    logic              resync;

    logic [RATE_W-1:0] sub_inc;
    logic              sec_roll;
    logic [3:0]        pre_inc;
    logic              pre_wrap;
    logic [6:0]        hund_inc;
    logic              hund_roll;
    logic [8:0]        sec_inc;
    logic [8:0]        min_inc;
    logic [8:0]        hour_inc;

    always_comb
    begin
        sub_inc   = sub_reg + 1'b1;
        sec_roll  = (sub_inc >= rate_reg);
        pre_inc   = prescale_reg + 1'b1;
        pre_wrap  = (pre_inc > limit_reg);
        hund_inc  = hund_reg + {6'd0, pre_wrap};
        hund_roll = (hund_inc >= HUNDREDTHS_LIMIT);
        sec_inc   = {1'b0, sec_reg} + 9'd1;
        min_inc   = {1'b0, min_reg} + 9'd1;
        hour_inc  = {1'b0, hour_reg} + 9'd1;

        prescale_next = prescale_reg;
        hund_next     = hund_reg;
        sec_next      = sec_reg;
        min_next      = min_reg;
        hour_next     = hour_reg;
        sub_next      = sub_reg;
        uptime_next   = uptime_reg;
        base_next     = base_reg;
        total_next    = total_reg;
        resync        = 1'b0;

        if (item.mode == MODE_LOAD)
        begin
            sec_next  = bcd_to_bin(item.load_second_bcd);
            min_next  = bcd_to_bin(item.load_minute_bcd);
            hour_next = bcd_to_bin(item.load_hour_bcd);
        end
        else
        begin
            total_next    = total_reg + 32'd1;
            sub_next      = sec_roll ? '0 : sub_inc;
            uptime_next   = uptime_reg + {31'd0, sec_roll};
            base_next     = sec_roll ? (base_reg + CENTI_STEP) : base_reg;
            resync        = sec_roll && (mod10(min_reg) == 4'd0);
            prescale_next = pre_wrap ? 4'd0 : pre_inc;
            hund_next     = hund_roll ? 7'd0 : hund_inc;
            if (hund_roll)
            begin
                if (sec_inc >= MINSEC_LIMIT)
                begin
                    sec_next = 8'd0;
                    if (min_inc >= MINSEC_LIMIT)
                    begin
                        min_next  = 8'd0;
                        hour_next = (hour_inc >= HOUR_LIMIT) ? 8'd0 : hour_inc[7:0];
                    end
                    else
                    begin
                        min_next = min_inc[7:0];
                    end
                end
                else
                begin
                    sec_next = sec_inc[7:0];
                end
            end
        end
    end

    always_comb
    begin
        result.hundredths     = hund_next;
        result.seconds        = sec_next;
        result.minutes        = min_next;
        result.hours          = hour_next;
        result.boot_seconds   = uptime_next;
        result.precise_time   = base_next + {23'd0, sub_next[RATE_W-1:1]};
        result.tick_count     = total_next;
        result.resync_request = resync;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= RATE_RESET;
            limit_reg <= PRESCALE_RESET;
        end
        else if (cfg_wr.we)
        begin
            rate_reg  <= cfg_wr.data;
            limit_reg <= div100(cfg_wr.data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            hund_reg     <= '0;
            sec_reg      <= '0;
            min_reg      <= '0;
            hour_reg     <= '0;
            sub_reg      <= '0;
            uptime_reg   <= '0;
            base_reg     <= '0;
            total_reg    <= '0;
        end
        else if (step)
        begin
            prescale_reg <= prescale_next;
            hund_reg     <= hund_next;
            sec_reg      <= sec_next;
            min_reg      <= min_next;
            hour_reg     <= hour_next;
            sub_reg      <= sub_next;
            uptime_reg   <= uptime_next;
            base_reg     <= base_next;
            total_reg    <= total_next;
        end
    end

    `TDC_ASSERT_SAME(a_hund_range, 1'b1, hund_reg < HUNDREDTHS_LIMIT, "hundredths out of range")
    `TDC_ASSERT_SAME(a_prescale_range, 1'b1, prescale_reg <= 4'd10, "prescaler out of range")
    `TDC_ASSERT_SAME(a_base_tracks, 1'b1, base_reg == uptime_reg * CENTI_STEP, "base mismatch")
    `TDC_ASSERT_NEXT(a_load_holds, step && (item.mode == MODE_LOAD),
        $stable(total_reg) && $stable(sub_reg) && $stable(hund_reg), "load moved counters")
    `TDC_ASSERT_NEXT(a_idle_holds, !step, $stable(total_reg) && $stable(sec_reg),
        "state moved without a request")

endmodule

// ===== design/tick_driven_time_of_day_clock_unit.sv =====
// Top level of the time-of-day clock unit: input stage, clock core and
// result register. Depends on tdc_pkg, tdc_ifs, tdc_in_stage and tdc_core.
//
//  channel  dir  content
//  ticks    in   tick or BCD load request (mode, three BCD bytes)
//  results  out  clock fields, boot seconds, precise time, tick count, resync
//  cfg      in   tick_rate write, always ready
//
// One request per cycle sustained while results are taken; a request passes
// the input register, then the single-pass core, into the result register.
// rst_n clears all counters and sets tick_rate to 200.
// A stalled result holds the core; the input register still takes one more
// request, then ready drops until the result is taken.
module tick_driven_time_of_day_clock_unit
(
    input  logic          clk,
    input  logic          rst_n,
    tdc_cfg_if.sink       cfg,
    tdc_item_if.sink      ticks,
    tdc_result_if.source  results
);
    import tdc_pkg::*;

    logic    held_valid;
    item_t   held_item;
    logic    take;
    cfg_wr_t cfg_wr;
    result_t core_result;
    logic    out_valid_reg;
    result_t out_reg;

    assign cfg.ready   = 1'b1;
    assign cfg_wr.we   = cfg.valid;
    assign cfg_wr.data = cfg.data;

    assign take = held_valid && (!out_valid_reg || results.ready);

    tdc_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (ticks),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    tdc_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .step   (take),
        .item   (held_item),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= core_result;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

endmodule
